// ===== sv/oarb_pkg.sv =====
// ----------------------------------------------------------------------------
// oarb_pkg
// shared types, constants and command encoding for the overlap-add ring buffer
// ----------------------------------------------------------------------------
package oarb_pkg;

	localparam int DEPTH_DEF      = 2048;
	localparam int MAX_WINDOW_DEF = 64;

	localparam int SIZE_W   = 12;
	localparam int SAMPLE_W = 16;
	localparam int AMOUNT_W = 13;
	localparam int REQ_W    = 4;
	localparam int WIN_W    = 7;
	localparam int TOTAL_W  = 32;
	localparam int MAG_W    = 13;
	localparam int X_W      = 14;
	localparam int STEP_W   = 4;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 12'd2048;

	localparam logic [REQ_W-1:0] REQ_PUSH       = 4'd0;
	localparam logic [REQ_W-1:0] REQ_ADD        = 4'd1;
	localparam logic [REQ_W-1:0] REQ_READ       = 4'd2;
	localparam logic [REQ_W-1:0] REQ_READ_CLEAR = 4'd3;
	localparam logic [REQ_W-1:0] REQ_WINDOW     = 4'd4;
	localparam logic [REQ_W-1:0] REQ_SHIFT_WR   = 4'd5;
	localparam logic [REQ_W-1:0] REQ_SHIFT_RD   = 4'd6;
	localparam logic [REQ_W-1:0] REQ_BEHIND     = 4'd7;
	localparam logic [REQ_W-1:0] REQ_COUNT      = 4'd8;

	typedef enum logic [3:0] {
		OP_PUSH,
		OP_ADD,
		OP_READ,
		OP_READ_CLR,
		OP_WINDOW,
		OP_SHIFT_WR,
		OP_SHIFT_RD,
		OP_BEHIND,
		OP_ZEROS
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                     op;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [AMOUNT_W-1:0] amount;
		logic        [WIN_W-1:0]    win_n;
		logic        [SIZE_W-1:0]   size;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_WIN,
		ST_ZERO
	} back_state_t;

endpackage

// ===== sv/oarb_mod.sv =====
// ----------------------------------------------------------------------------
// oarb_mod
// true modulo of a signed offset pointer by the ring size, one bit per cycle
// ----------------------------------------------------------------------------
module oarb_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [oarb_pkg::X_W-1:0]     x,
	input  logic [oarb_pkg::SIZE_W-1:0]  size,
	output logic                         done,
	output logic [oarb_pkg::SIZE_W-1:0]  r
);
	import oarb_pkg::*;

	logic                neg;
	logic [MAG_W-1:0]    mag;
	logic [MAG_W-1:0]    size_ext;
	logic                fast;
	logic [SIZE_W-1:0]   fast_r;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [MAG_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [SIZE_W-1:0]   size_q;
	logic                neg_q;
	logic [SIZE_W-1:0]   r_q;

	logic [MAG_W-1:0]    trial;
	logic [SIZE_W-1:0]   rem_n;
	logic [SIZE_W-1:0]   fin_r;

	always_comb begin
		neg      = x[X_W-1];
		mag      = neg ? MAG_W'(-x) : MAG_W'(x);
		size_ext = MAG_W'(size);
		// operand already within one ring length of range needs no iteration
		fast     = neg ? (mag <= size_ext) : (mag < size_ext);
		fast_r   = neg ? SIZE_W'(size_ext - mag) : SIZE_W'(mag);
	end

	always_comb begin
		trial = {rem_q, dvd_q[MAG_W-1]};
		if (trial >= MAG_W'(size_q)) begin
			rem_n = SIZE_W'(trial - MAG_W'(size_q));
		end else begin
			rem_n = SIZE_W'(trial);
		end
		fin_r = (neg_q && rem_n != '0) ? SIZE_W'(size_q - rem_n) : rem_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (fast) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(MAG_W);
				end
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= neg;
			size_q <= size;
			dvd_q  <= mag;
			rem_q  <= '0;
			r_q    <= fast_r;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_n;
			if (step_q == STEP_W'(1)) begin
				r_q <= fin_r;
			end
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

// ===== sv/oarb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// oarb_cmd_fifo
// short command queue between the front classifier and the back executor
// ----------------------------------------------------------------------------
module oarb_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  oarb_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output oarb_pkg::cmd_t   head
);
	import oarb_pkg::*;

	cmd_t                 slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign full       = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== sv/oarb_front.sv =====
// ----------------------------------------------------------------------------
// oarb_front
// request intake: size register, request decode and one classified stage
// ----------------------------------------------------------------------------
module oarb_front #(
	parameter int DEPTH      = oarb_pkg::DEPTH_DEF,
	parameter int MAX_WINDOW = oarb_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [oarb_pkg::REQ_W-1:0]         req_type,
	input  logic signed [oarb_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [oarb_pkg::AMOUNT_W-1:0] amount,
	input  logic                               cfg_we,
	input  logic [oarb_pkg::SIZE_W-1:0]        cfg_data,
	input  logic                               clearing,
	input  logic                               fifo_full,
	output logic                               busy,
	output logic                               push,
	output oarb_pkg::cmd_t                     push_cmd
);
	import oarb_pkg::*;

	logic [SIZE_W-1:0]  used_size_q;
	logic               valid_s1;
	cmd_t               cmd_s1;

	logic [SIZE_W-1:0]  eff_size;
	logic               size_zero;
	logic [WIN_W-1:0]   win_len;
	logic               keep;
	cmd_t               cls;
	logic               accept;

	always_comb begin
		if (32'(used_size_q) > 32'(DEPTH)) begin
			eff_size = SIZE_W'(DEPTH);
		end else begin
			eff_size = used_size_q;
		end
		size_zero = (eff_size == '0);
		if (amount > $signed(AMOUNT_W'(MAX_WINDOW))) begin
			win_len = WIN_W'(MAX_WINDOW);
		end else begin
			win_len = amount[WIN_W-1:0];
		end
	end

	// drop requests that have no effect and no result
	always_comb begin
		keep       = 1'b0;
		cls.op     = OP_ZEROS;
		cls.sample = sample_in;
		cls.amount = amount;
		cls.win_n  = WIN_W'(1);
		cls.size   = eff_size;
		unique case (req_type)
			REQ_PUSH: begin
				keep   = !size_zero;
				cls.op = OP_PUSH;
			end
			REQ_ADD: begin
				keep   = !size_zero;
				cls.op = OP_ADD;
			end
			REQ_READ: begin
				keep   = 1'b1;
				cls.op = size_zero ? OP_ZEROS : OP_READ;
			end
			REQ_READ_CLEAR: begin
				keep   = 1'b1;
				cls.op = size_zero ? OP_ZEROS : OP_READ_CLR;
			end
			REQ_WINDOW: begin
				keep      = (amount > $signed(AMOUNT_W'(0)));
				cls.op    = size_zero ? OP_ZEROS : OP_WINDOW;
				cls.win_n = win_len;
			end
			REQ_SHIFT_WR: begin
				keep   = !size_zero;
				cls.op = OP_SHIFT_WR;
			end
			REQ_SHIFT_RD: begin
				keep   = !size_zero;
				cls.op = OP_SHIFT_RD;
			end
			REQ_BEHIND: begin
				keep   = !size_zero && !amount[AMOUNT_W-1];
				cls.op = OP_BEHIND;
			end
			REQ_COUNT: begin
				keep   = 1'b1;
				cls.op = OP_ZEROS;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign busy     = clearing || (valid_s1 && fifo_full);
	assign accept   = start && !busy;
	assign push     = valid_s1 && !fifo_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_size_q <= SIZE_RESET;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				used_size_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= keep;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// ===== sv/oarb_back.sv =====
// ----------------------------------------------------------------------------
// oarb_back
// command executor: sample store, pointers, write count and result register
// ----------------------------------------------------------------------------
module oarb_back #(
	parameter int DEPTH = oarb_pkg::DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  oarb_pkg::cmd_t                       head,
	output logic                                 pop,
	output logic                                 clearing,
	output logic                                 strobe,
	output logic signed [oarb_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 last,
	output logic [oarb_pkg::TOTAL_W-1:0]         writes_done
);
	import oarb_pkg::*;

	localparam int AW = $clog2(DEPTH);

	back_state_t          state_q;
	back_state_t          next_state;

	cmd_t                 cur_q;
	logic [SIZE_W-1:0]    wp_q;
	logic [SIZE_W-1:0]    rp_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [SIZE_W-1:0]    idx_q;
	logic [WIN_W-1:0]     cnt_q;
	logic [AW-1:0]        clr_q;

	logic [SAMPLE_W-1:0]  store [DEPTH];
	logic [SAMPLE_W-1:0]  rd_q;

	logic                 strobe_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic                 last_q;
	logic [TOTAL_W-1:0]   writes_q;

	logic                 load_cur;
	logic                 mod_start;
	logic [X_W-1:0]       mod_x;
	logic                 mod_done;
	logic [SIZE_W-1:0]    mod_r;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [SAMPLE_W-1:0]  wdata;
	logic [AW-1:0]        raddr;
	logic                 emit;
	logic [SAMPLE_W-1:0]  emit_sample;
	logic                 emit_last;
	logic [SIZE_W-1:0]    wp_d;
	logic [SIZE_W-1:0]    rp_d;
	logic [TOTAL_W-1:0]   total_d;
	logic [SIZE_W-1:0]    idx_d;
	logic [WIN_W-1:0]     cnt_d;
	logic                 run_last;
	logic [SAMPLE_W:0]    sum;
	logic [SAMPLE_W-1:0]  avg;
	logic [X_W-1:0]       amt_x;

	function automatic logic [SIZE_W-1:0] ptr_inc(input logic [SIZE_W-1:0] p,
		input logic [SIZE_W-1:0] size);
		if ((SIZE_W + 1)'(p) + 1'b1 == (SIZE_W + 1)'(size)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	oarb_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.size   (head.size),
		.done   (mod_done),
		.r      (mod_r)
	);

	// pointer offset for the remainder unit, taken from the queue head
	always_comb begin
		amt_x = {head.amount[AMOUNT_W-1], head.amount};
		case (head.op) inside
			OP_READ, OP_READ_CLR: mod_x = X_W'(rp_q);
			OP_WINDOW:            mod_x = X_W'(wp_q) - X_W'(head.win_n);
			OP_SHIFT_WR:          mod_x = X_W'(wp_q) + amt_x;
			OP_SHIFT_RD:          mod_x = X_W'(rp_q) + amt_x;
			OP_BEHIND:            mod_x = X_W'(wp_q) - amt_x;
			default:              mod_x = X_W'(wp_q);
		endcase
	end

	// add rounds toward minus infinity
	always_comb begin
		sum = {cur_q.sample[SAMPLE_W-1], cur_q.sample} + {rd_q[SAMPLE_W-1], rd_q};
		avg = sum[SAMPLE_W:1];
	end

	assign run_last = (cnt_q == WIN_W'(cur_q.win_n - 1'b1));

	always_comb begin
		next_state = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					next_state = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					next_state = (head.op == OP_ZEROS) ? ST_ZERO : ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					case (cur_q.op) inside
						OP_ADD, OP_READ, OP_READ_CLR: next_state = ST_RD;
						OP_WINDOW:                    next_state = ST_WIN;
						default:                      next_state = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				next_state = ST_IDLE;
			end
			ST_WIN, ST_ZERO: begin
				if (run_last) begin
					next_state = ST_IDLE;
				end
			end
			default: begin
				next_state = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop         = 1'b0;
		load_cur    = 1'b0;
		mod_start   = 1'b0;
		we          = 1'b0;
		waddr       = AW'(idx_q);
		wdata       = '0;
		raddr       = AW'(idx_q);
		emit        = 1'b0;
		emit_sample = '0;
		emit_last   = 1'b0;
		wp_d        = wp_q;
		rp_d        = rp_q;
		total_d     = total_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop       = 1'b1;
					load_cur  = 1'b1;
					cnt_d     = '0;
					mod_start = (head.op != OP_ZEROS);
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					case (cur_q.op)
						OP_PUSH: begin
							we      = 1'b1;
							waddr   = AW'(mod_r);
							wdata   = cur_q.sample;
							wp_d    = ptr_inc(mod_r, cur_q.size);
							total_d = total_q + 1'b1;
						end
						OP_ADD, OP_READ, OP_READ_CLR: begin
							raddr = AW'(mod_r);
							idx_d = mod_r;
						end
						OP_WINDOW: begin
							raddr = AW'(mod_r);
							idx_d = ptr_inc(mod_r, cur_q.size);
						end
						OP_SHIFT_WR: begin
							wp_d = mod_r;
						end
						OP_SHIFT_RD, OP_BEHIND: begin
							rp_d = mod_r;
						end
						default: begin
						end
					endcase
				end
			end
			ST_RD: begin
				if (cur_q.op == OP_ADD) begin
					we      = 1'b1;
					wdata   = avg;
					wp_d    = ptr_inc(idx_q, cur_q.size);
					total_d = total_q + 1'b1;
				end else begin
					emit        = 1'b1;
					emit_sample = rd_q;
					emit_last   = 1'b1;
					rp_d        = ptr_inc(idx_q, cur_q.size);
					we          = (cur_q.op == OP_READ_CLR);
				end
			end
			ST_WIN: begin
				// one read in flight: data for element k arrives as k is sent
				emit        = 1'b1;
				emit_sample = rd_q;
				emit_last   = run_last;
				idx_d       = ptr_inc(idx_q, cur_q.size);
				cnt_d       = cnt_q + 1'b1;
			end
			ST_ZERO: begin
				emit      = 1'b1;
				emit_last = run_last;
				cnt_d     = cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			wp_q     <= '0;
			rp_q     <= '0;
			total_q  <= '0;
			clr_q    <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= next_state;
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			total_q  <= total_d;
			cnt_q    <= cnt_d;
			strobe_q <= emit;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (load_cur) begin
			cur_q <= head;
		end
		if (emit) begin
			sample_q <= emit_sample;
			last_q   <= emit_last;
			writes_q <= total_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store[waddr] <= wdata;
		end
		rd_q <= store[raddr];
	end

	assign clearing    = (state_q == ST_CLEAR);
	assign strobe      = strobe_q;
	assign sample_out  = sample_q;
	assign last        = last_q;
	assign writes_done = writes_q;

endmodule

// ===== sv/overlap_add_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overlap_add_ring_buffer
// ring store of Q1.15 audio samples with push, average-add, reads and windows
// ----------------------------------------------------------------------------
//  channel   signals                               direction  flow
//  request   start, req_type, sample_in, amount    in         start & !busy
//  result    strobe, sample_out, last, writes_done out        strobe, no stall
//  config    cfg_we, cfg_data (used_size)          in         cfg_we, no wait
//
//  the front stage takes one request a cycle while busy is low into a
//  two-entry command queue; commands go from idle to the remainder state,
//  then to the read state for add, read and read-clear or to the window
//  state for windows; zero results and count query go to the zero state.
//  the remainder unit iterates only for an offset pointer outside one ring
//  length, after a size change or a long shift. results cannot be held off;
//  busy rises only while the store is zeroed after reset or the queue backs up
// ----------------------------------------------------------------------------
module overlap_add_ring_buffer #(
	parameter int DEPTH      = oarb_pkg::DEPTH_DEF,
	parameter int MAX_WINDOW = oarb_pkg::MAX_WINDOW_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [oarb_pkg::REQ_W-1:0]           req_type,
	input  logic signed [oarb_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [oarb_pkg::AMOUNT_W-1:0] amount,
	input  logic                                 cfg_we,
	input  logic [oarb_pkg::SIZE_W-1:0]          cfg_data,
	output logic                                 strobe,
	output logic signed [oarb_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                 last,
	output logic [oarb_pkg::TOTAL_W-1:0]         writes_done
);
	import oarb_pkg::*;

	logic  clearing;
	logic  fifo_full;
	logic  push;
	cmd_t  push_cmd;
	logic  pop;
	logic  head_valid;
	cmd_t  head;

	oarb_front #(
		.DEPTH      (DEPTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.sample_in (sample_in),
		.amount    (amount),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.clearing  (clearing),
		.fifo_full (fifo_full),
		.busy      (busy),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	oarb_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (fifo_full),
		.head_valid (head_valid),
		.head       (head)
	);

	oarb_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.clearing    (clearing),
		.strobe      (strobe),
		.sample_out  (sample_out),
		.last        (last),
		.writes_done (writes_done)
	);

endmodule
